// ===== sv/uthp_pkg.sv =====
// Shared types, constants and codes for the UUID text parser and hash block.
package uthp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [31:0] hash_value;
        logic        well_formed;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINAL,
        S_DONE
    } t_hash_state;

    typedef enum logic [1:0] {
        PH_OPEN = 2'd0,
        PH_HIGH = 2'd1,
        PH_DASH = 2'd2
    } t_phase;

    typedef struct packed {
        logic         start;
        logic [127:0] id;
        logic         ok;
    } t_hash_req;

    localparam logic [31:0] MUR_MAGIC  = 32'h5bd1e995;
    localparam logic [31:0] HASH_INIT  = 32'd16;
    localparam logic [7:0]  CH_DASH    = 8'h2d;
    localparam logic [7:0]  CH_LBRACE  = 8'h7b;
    localparam logic [7:0]  CH_RBRACE  = 8'h7d;
    localparam logic [5:0]  PLAIN_LAST_IDX  = 6'd35;
    localparam logic [5:0]  BRACED_LAST_IDX = 6'd37;
    localparam logic [5:0]  COUNT_MAX       = 6'd63;
    localparam logic [4:0]  ID_BYTES        = 5'd16;

endpackage

// ===== sv/uthp_track.sv =====
// One parse track: dash skipping, hex digit pairing and byte storage.
module uthp_track
    import uthp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_feed,
    input  logic         i_clear,
    input  logic [7:0]   i_ch,
    output logic [127:0] o_bytes
);

    logic [7:0] r_bytes [16];
    logic [4:0] r_cursor, n_cursor;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_nibble, n_nibble;
    logic       n_wr;
    logic [7:0] n_wr_data;
    logic [3:0] w_hex;

    function automatic logic [3:0] f_hex(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            v = c[3:0];
        end else if ((c >= 8'd97 && c <= 8'd102) || (c >= 8'd65 && c <= 8'd70)) begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

    assign w_hex = f_hex(i_ch);

    always_comb begin
        n_cursor  = r_cursor;
        n_phase   = r_phase;
        n_nibble  = r_nibble;
        n_wr      = 1'b0;
        n_wr_data = {r_nibble, w_hex};
        if (i_feed && !r_cursor[4]) begin
            if (r_phase == PH_HIGH) begin
                n_wr     = 1'b1;
                n_cursor = 5'(r_cursor + 5'd1);
                n_phase  = PH_OPEN;
            end else if (r_phase == PH_OPEN && i_ch == CH_DASH) begin
                n_phase = PH_DASH;
            end else begin
                n_nibble = w_hex;
                n_phase  = PH_HIGH;
            end
        end
    end

    // finished view: bytes below the cursor, a pending high nibble, zeros beyond
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            if (n_wr && r_cursor[3:0] == 4'(j)) begin
                o_bytes[127 - 8*j -: 8] = n_wr_data;
            end else if (5'(j) < r_cursor) begin
                o_bytes[127 - 8*j -: 8] = r_bytes[j];
            end else if (5'(j) == n_cursor && n_phase == PH_HIGH) begin
                o_bytes[127 - 8*j -: 8] = {n_nibble, 4'd0};
            end else begin
                o_bytes[127 - 8*j -: 8] = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cursor <= 5'd0;
            r_phase  <= PH_OPEN;
            r_nibble <= 4'd0;
        end else begin
            r_cursor <= n_cursor;
            r_phase  <= n_phase;
            r_nibble <= n_nibble;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_bytes[r_cursor[3:0]] <= n_wr_data;
        end
    end

endmodule

// ===== sv/uthp_hash.sv =====
// Iterative MurmurHash2 over a 16-byte id with one shared 32x32 multiplier.
module uthp_hash
    import uthp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_hash_req i_req,
    input  logic      i_take,
    output logic      o_busy,
    output logic      o_valid,
    output t_out      o_result
);

    t_hash_state  r_state, n_state;
    logic [127:0] r_id, r_key;
    logic         r_ok, r_nonzero;
    logic [31:0]  r_k, r_h;
    logic [1:0]   r_sub, r_word;
    logic [31:0]  w_a;
    logic [63:0]  w_full;
    logic [31:0]  w_prod;
    logic [31:0]  w_word;

    assign w_word = {r_key[103:96], r_key[111:104], r_key[119:112], r_key[127:120]};

    always_comb begin
        w_a = r_h;
        case (r_state)
            S_RUN: begin
                case (r_sub)
                    2'd0:    w_a = w_word;
                    2'd1:    w_a = r_k ^ (r_k >> 24);
                    default: w_a = r_h;
                endcase
            end
            S_FINAL: w_a = r_h ^ (r_h >> 13);
            default: w_a = r_h;
        endcase
    end

    assign w_full = w_a * MUR_MAGIC;
    assign w_prod = w_full[31:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_word == 2'd3 && r_sub == 2'd2) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: n_state = S_DONE;
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy              = (r_state != S_IDLE);
        o_valid             = (r_state == S_DONE);
        o_result.id_high    = r_id[127:64];
        o_result.id_low     = r_id[63:0];
        o_result.hash_value = r_nonzero ? (r_h ^ (r_h >> 15)) : 32'd0;
        o_result.well_formed = r_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sub   <= 2'd0;
            r_word  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN) begin
                if (r_sub == 2'd2) begin
                    r_sub  <= 2'd0;
                    r_word <= 2'(r_word + 2'd1);
                end else begin
                    r_sub <= 2'(r_sub + 2'd1);
                end
            end else begin
                r_sub  <= 2'd0;
                r_word <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.start) begin
            r_id      <= i_req.id;
            r_key     <= i_req.id;
            r_ok      <= i_req.ok;
            r_nonzero <= |i_req.id;
            r_h       <= HASH_INIT;
        end else if (r_state == S_RUN) begin
            case (r_sub)
                2'd0: r_k <= w_prod;
                2'd1: r_k <= w_prod;
                default: begin
                    r_h   <= w_prod ^ r_k;
                    r_key <= {r_key[95:0], 32'd0};
                end
            endcase
        end else if (r_state == S_FINAL) begin
            r_h <= w_prod;
        end
    end

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_take) |=> (o_valid && $stable(r_h) && $stable(r_id)))
        else $error("hash result changed while waiting");
    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |-> (r_word == 2'd0 && r_sub == 2'd0 && $past(r_word) == 2'd3))
        else $error("hash ran a wrong number of steps");
    a_zero_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_id == 128'd0) |-> (o_result.hash_value == 32'd0))
        else $error("all-zero id gave a nonzero hash");

endmodule

// ===== sv/uuid_text_parse_and_hash_top.sv =====
// Top level of the UUID text parser with MurmurHash2 digest.
// Characters enter one beat per cycle while the hash unit is idle; plain and braced tracks parse them in parallel.
// A beat without last produces no result. A beat with last
// hands the selected 16-byte id to the hash unit, whose single 32x32 multiplier runs
// 12 word steps and one final step. The input then stays not ready until the result
// has moved into the output register. That happens once the hash unit is done if
// the output register is free, and later while it still holds an untaken result.
// The output register lets the next text stream in while a result waits to be taken.
module uuid_text_parse_and_hash_top
    import uthp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic [5:0]   r_char_count;
    logic         r_opens_brace;
    logic         r_out_valid;
    t_out         r_out;
    logic         w_accept, w_end;
    logic [127:0] w_plain, w_braced;
    t_hash_req    w_req;
    logic         w_busy, w_hvalid, w_take;
    t_out         w_hresult;
    logic         w_braced_ok, w_plain_ok;

    assign o_in_ready = !w_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_end      = w_accept && i_in.last;

    uthp_track u_plain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_feed  (w_accept),
        .i_clear (w_end),
        .i_ch    (i_in.ch),
        .o_bytes (w_plain)
    );

    uthp_track u_braced (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_feed  (w_accept && (r_char_count != 6'd0)),
        .i_clear (w_end),
        .i_ch    (i_in.ch),
        .o_bytes (w_braced)
    );

    always_comb begin
        w_braced_ok = (r_char_count == BRACED_LAST_IDX) && r_opens_brace
                      && (i_in.ch == CH_RBRACE);
        w_plain_ok  = (r_char_count == PLAIN_LAST_IDX);
        w_req.start = w_end;
        w_req.ok    = w_braced_ok || w_plain_ok;
        if (w_braced_ok) begin
            w_req.id = w_braced;
        end else if (w_plain_ok) begin
            w_req.id = w_plain;
        end else begin
            w_req.id = 128'd0;
        end
    end

    uthp_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_take   (w_take),
        .o_busy   (w_busy),
        .o_valid  (w_hvalid),
        .o_result (w_hresult)
    );

    assign w_take = w_hvalid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_end) begin
            r_char_count  <= 6'd0;
            r_opens_brace <= 1'b0;
        end else if (w_accept) begin
            if (r_char_count != COUNT_MAX) begin
                r_char_count <= 6'(r_char_count + 6'd1);
            end
            if (r_char_count == 6'd0 && i_in.ch == CH_LBRACE) begin
                r_opens_brace <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_hresult;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.well_formed) |->
        (r_out.id_high == 64'd0 && r_out.id_low == 64'd0 && r_out.hash_value == 32'd0))
        else $error("rejected text produced a nonzero result");
    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> (r_char_count == 6'd0 && !r_opens_brace && w_busy))
        else $error("last beat did not restart parsing and start hashing");
    a_hash_needs_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hash_value != 32'd0) |->
        (r_out.id_high != 64'd0 || r_out.id_low != 64'd0))
        else $error("nonzero hash for an all-zero id");

endmodule
